// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every edge outside reset
`define KOVH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kovh assertion failed");
// expression never true outside reset
`define KOVH_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("kovh assertion failed");
`else
`define KOVH_ASSERT(label, clk, rst, prop)
`define KOVH_NEVER(label, clk, rst, expr)
`endif
`endif

// File: sv/kovh_pkg.sv
// ----------------------------------------------------------------------------
// kovh_pkg
// constants, types and helpers of the k-mer overlap histogram
// ----------------------------------------------------------------------------
package kovh_pkg;

   localparam int ALPHABET    = 8;
   localparam int COUNT_BITS  = 48;
   localparam int KEY_W       = 59;
   localparam int LETTER_W    = 4;
   localparam int BIN_INDEX_W = 4;
   localparam int VALUE_W     = 48;

   localparam int NUM_BINS    = ALPHABET + 1;
   localparam int NUM_RESULTS = ALPHABET + 2;
   localparam int LAST_IDX    = ALPHABET + 1;
   localparam int IDX_W       = $clog2(NUM_RESULTS);
   localparam int BSEL_W      = $clog2(NUM_BINS);
   localparam int CNT_W       = $clog2(ALPHABET + 1);
   localparam int INC_W       = CNT_W + 2;
   localparam int PROD_W      = 2 * CNT_W + 1;

   typedef logic [KEY_W-1:0]       key_type;
   typedef logic [LETTER_W-1:0]    letter_type;
   typedef logic [ALPHABET-1:0]    mask_type;
   typedef logic [CNT_W-1:0]       cnt_type;
   typedef logic [IDX_W-1:0]       idx_type;
   typedef logic [BSEL_W-1:0]      bsel_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [COUNT_BITS:0]    count_wide_type;
   typedef logic [INC_W-1:0]       inc_type;
   typedef logic [PROD_W-1:0]      prod_type;
   typedef logic [BIN_INDEX_W-1:0] bin_index_type;
   typedef logic [VALUE_W-1:0]     value_type;

   // one closed group: distinct letter counts on each side
   typedef struct packed {
      logic    hit;
      cnt_type c0;
      cnt_type c1;
   } grp_close_type;

   // what one record hands to the histogram: a close on key change,
   // the close of its own group on end of stream, and the drain request
   typedef struct packed {
      grp_close_type first;
      grp_close_type second;
      logic          eos;
   } grp_event_type;

   function automatic cnt_type popcount(input mask_type m);
      cnt_type n;
      n = '0;
      for (int i = 0; i < ALPHABET; i++) begin
         n = n + cnt_type'(m[i]);
      end
      return n;
   endfunction

   function automatic count_type sat_add(input count_type a, input count_type b);
      count_wide_type s;
      s = count_wide_type'(a) + count_wide_type'(b);
      if (s[COUNT_BITS]) begin
         return {COUNT_BITS{1'b1}};
      end
      return s[COUNT_BITS-1:0];
   endfunction

endpackage

// File: sv/kovh_group.sv
// ----------------------------------------------------------------------------
// kovh_group
// input register and group tracking: letter masks per side, group closes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kovh_group (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  kovh_pkg::key_type      in_kmer_key,
   input  kovh_pkg::letter_type   in_letter,
   input  logic                   in_side,
   input  logic                   in_end_of_stream,
   output kovh_pkg::grp_event_type evt
);

   logic                 s1_valid_ff;
   kovh_pkg::key_type    s1_key_ff;
   kovh_pkg::letter_type s1_letter_ff;
   logic                 s1_side_ff;
   logic                 s1_eos_ff;

   logic                 open_ff, open_in;
   kovh_pkg::key_type    key_ff, key_in;
   kovh_pkg::mask_type   mask0_ff, mask0_in;
   kovh_pkg::mask_type   mask1_ff, mask1_in;
   kovh_pkg::grp_event_type evt_ff, evt_in;

   logic                 key_change;
   logic                 letter_hit;
   kovh_pkg::mask_type   letter_dec;
   kovh_pkg::mask_type   new0;
   kovh_pkg::mask_type   new1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept) begin
         s1_key_ff    <= in_kmer_key;
         s1_letter_ff <= in_letter;
         s1_side_ff   <= in_side;
         s1_eos_ff    <= in_end_of_stream;
      end
   end

   always_comb begin
      key_change = s1_valid_ff && open_ff && (s1_key_ff != key_ff);
      letter_hit = int'(s1_letter_ff) < kovh_pkg::ALPHABET;
      letter_dec = letter_hit ? (kovh_pkg::mask_type'(1) << s1_letter_ff) : '0;

      // a new group starts from empty masks
      if (open_ff && !key_change) begin
         new0 = mask0_ff;
         new1 = mask1_ff;
      end else begin
         new0 = '0;
         new1 = '0;
      end
      if (s1_side_ff) begin
         new1 = new1 | letter_dec;
      end else begin
         new0 = new0 | letter_dec;
      end

      evt_in.first.hit  = key_change;
      evt_in.first.c0   = kovh_pkg::popcount(mask0_ff);
      evt_in.first.c1   = kovh_pkg::popcount(mask1_ff);
      evt_in.second.hit = s1_valid_ff && s1_eos_ff;
      evt_in.second.c0  = kovh_pkg::popcount(new0);
      evt_in.second.c1  = kovh_pkg::popcount(new1);
      evt_in.eos        = s1_valid_ff && s1_eos_ff;

      open_in  = open_ff;
      key_in   = key_ff;
      mask0_in = mask0_ff;
      mask1_in = mask1_ff;
      if (s1_valid_ff) begin
         if (s1_eos_ff) begin
            open_in  = 1'b0;
            key_in   = '0;
            mask0_in = '0;
            mask1_in = '0;
         end else begin
            open_in  = 1'b1;
            key_in   = s1_key_ff;
            mask0_in = new0;
            mask1_in = new1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         key_ff   <= '0;
         mask0_ff <= '0;
         mask1_ff <= '0;
         evt_ff   <= '0;
      end else begin
         open_ff  <= open_in;
         key_ff   <= key_in;
         mask0_ff <= mask0_in;
         mask1_ff <= mask1_in;
         evt_ff   <= evt_in;
      end
   end

   assign evt = evt_ff;

   `KOVH_ASSERT(eos_clears_group, clock, reset, s1_valid_ff && s1_eos_ff |=> !open_ff && mask0_ff == '0 && mask1_ff == '0 && evt_ff.second.hit)

endmodule

// File: sv/kovh_hist.sv
// ----------------------------------------------------------------------------
// kovh_hist
// overlap bins and pair total with saturating update, drain to result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kovh_hist (
   input  logic                          clock,
   input  logic                          reset,
   input  kovh_pkg::grp_event_type       evt,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output kovh_pkg::bin_index_type       rsp_bin_index,
   output kovh_pkg::value_type           rsp_bin_value,
   output logic                          rsp_last_of_run
);

   kovh_pkg::count_type bins_ff [kovh_pkg::NUM_BINS];
   kovh_pkg::count_type bins_in [kovh_pkg::NUM_BINS];
   kovh_pkg::count_type total_ff, total_in;
   logic                drain_ff, drain_in;
   kovh_pkg::idx_type   idx_ff, idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   kovh_pkg::bin_index_type   rsp_index_ff, rsp_index_in;
   kovh_pkg::value_type       rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff, rsp_last_in;

   kovh_pkg::inc_type   inc;
   kovh_pkg::prod_type  prod_a;
   kovh_pkg::prod_type  prod_b;
   kovh_pkg::count_type drain_word;
   logic                load;
   logic                at_last;

   always_comb begin
      // contributions of both closes go into each bin as one sum
      for (int j = 0; j < kovh_pkg::NUM_BINS; j++) begin
         inc = '0;
         if (evt.first.hit && int'(evt.first.c1) == j) begin
            inc = inc + kovh_pkg::inc_type'(evt.first.c0);
         end
         if (evt.first.hit && int'(evt.first.c0) == j) begin
            inc = inc + kovh_pkg::inc_type'(evt.first.c1);
         end
         if (evt.second.hit && int'(evt.second.c1) == j) begin
            inc = inc + kovh_pkg::inc_type'(evt.second.c0);
         end
         if (evt.second.hit && int'(evt.second.c0) == j) begin
            inc = inc + kovh_pkg::inc_type'(evt.second.c1);
         end
         bins_in[j] = kovh_pkg::sat_add(bins_ff[j], kovh_pkg::count_type'(inc));
      end

      prod_a = evt.first.hit ?
               kovh_pkg::prod_type'(kovh_pkg::prod_type'(evt.first.c0) *
                                    kovh_pkg::prod_type'(evt.first.c1)) : '0;
      prod_b = evt.second.hit ?
               kovh_pkg::prod_type'(kovh_pkg::prod_type'(evt.second.c0) *
                                    kovh_pkg::prod_type'(evt.second.c1)) : '0;
      total_in = kovh_pkg::sat_add(total_ff, kovh_pkg::count_type'(prod_a + prod_b));

      at_last = int'(idx_ff) == kovh_pkg::LAST_IDX;
      if (at_last) begin
         drain_word = total_ff;
      end else begin
         drain_word = bins_ff[idx_ff[kovh_pkg::BSEL_W-1:0]];
      end

      load     = drain_ff && (!rsp_valid_ff || rsp_ready);
      drain_in = drain_ff;
      idx_in   = idx_ff;
      if (evt.eos) begin
         drain_in = 1'b1;
         idx_in   = '0;
      end else if (load) begin
         idx_in = idx_ff + kovh_pkg::idx_type'(1);
         if (at_last) begin
            drain_in = 1'b0;
         end
      end

      // last word taken into the result register empties the store
      if (load && at_last) begin
         for (int j = 0; j < kovh_pkg::NUM_BINS; j++) begin
            bins_in[j] = '0;
         end
         total_in = '0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = kovh_pkg::bin_index_type'(idx_ff);
         rsp_value_in = kovh_pkg::value_type'(drain_word);
         rsp_last_in  = at_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < kovh_pkg::NUM_BINS; j++) begin
            bins_ff[j] <= '0;
         end
         total_ff     <= '0;
         drain_ff     <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int j = 0; j < kovh_pkg::NUM_BINS; j++) begin
            bins_ff[j] <= bins_in[j];
         end
         total_ff     <= total_in;
         drain_ff     <= drain_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bin_index   = rsp_index_ff;
   assign rsp_bin_value   = rsp_value_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `KOVH_NEVER(no_update_in_drain, clock, reset, drain_ff && (evt.first.hit || evt.second.hit || evt.eos))
   `KOVH_ASSERT(drain_end_clears, clock, reset, load && at_last |=> !drain_ff && total_ff == '0 && rsp_last_ff)

endmodule

// File: sv/kmer_overlap_histogram_top.sv
// ----------------------------------------------------------------------------
// kmer_overlap_histogram_top
// overlap histogram over a sorted stream of k-mer records
// ----------------------------------------------------------------------------
// ordinary records: one accepted per cycle while req_ready is high, no result word
// end of stream: first of ALPHABET+2 result words via input, event, drain regs,
// then one word per cycle while rsp_ready is high; the drain sequencer sets this
// req_ready is low from the end-of-stream accept until the final word is taken
// synchronous reset clears groups, bins, total and all handshake state
`include "assert_macros.svh"

module kmer_overlap_histogram_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  kovh_pkg::key_type             req_kmer_key,
   input  kovh_pkg::letter_type          req_letter,
   input  logic                          req_side,
   input  logic                          req_end_of_stream,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output kovh_pkg::bin_index_type       rsp_bin_index,
   output kovh_pkg::value_type           rsp_bin_value,
   output logic                          rsp_last_of_run
);

   logic                    busy_ff, busy_in;
   logic                    req_accept;
   kovh_pkg::grp_event_type evt;

   assign req_ready  = !busy_ff;
   assign req_accept = req_valid && req_ready;

   // busy from the end-of-stream word until the drain is fully taken
   always_comb begin
      busy_in = busy_ff;
      if (req_accept && req_end_of_stream) begin
         busy_in = 1'b1;
      end else if (rsp_valid && rsp_ready && rsp_last_of_run) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   kovh_group u_group (
      .clock            (clock),
      .reset            (reset),
      .in_accept        (req_accept),
      .in_kmer_key      (req_kmer_key),
      .in_letter        (req_letter),
      .in_side          (req_side),
      .in_end_of_stream (req_end_of_stream),
      .evt              (evt)
   );

   kovh_hist u_hist (
      .clock           (clock),
      .reset           (reset),
      .evt             (evt),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_bin_index   (rsp_bin_index),
      .rsp_bin_value   (rsp_bin_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   `KOVH_ASSERT(result_only_when_busy, clock, reset, rsp_valid |-> busy_ff)

endmodule

// File: dv/tb_kmer_overlap_histogram_top.sv
// ----------------------------------------------------------------------------
// tb_kmer_overlap_histogram_top
// self-checking bench for the k-mer overlap histogram: record streams go in
// through a valid/ready port and every drained bin word is checked against a
// local predictor of the grouping, letter masks, bins and pair total
// ----------------------------------------------------------------------------
module tb_kmer_overlap_histogram_top;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 20;
   localparam kovh_pkg::count_type COUNT_MAX = {kovh_pkg::COUNT_BITS{1'b1}};

   typedef struct packed {
      kovh_pkg::bin_index_type idx;
      kovh_pkg::value_type     value;
      logic                    last;
   } bin_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   kovh_pkg::key_type       req_kmer_key = '0;
   kovh_pkg::letter_type    req_letter = '0;
   logic                    req_side = 1'b0;
   logic                    req_end_of_stream = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   kovh_pkg::bin_index_type rsp_bin_index;
   kovh_pkg::value_type     rsp_bin_value;
   logic                    rsp_last_of_run;

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int error_count     = 0;
   int records_sent    = 0;
   int words_checked   = 0;
   int drains_seen     = 0;
   int idle_cycles     = 0;

   // predicted state of the histogram
   kovh_pkg::key_type   grp_key;
   logic                grp_open;
   kovh_pkg::mask_type  grp_side0;
   kovh_pkg::mask_type  grp_side1;
   kovh_pkg::count_type hist_bins [kovh_pkg::NUM_BINS];
   kovh_pkg::count_type hist_total;
   bin_word_type        pending_bins [$];

   kmer_overlap_histogram_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kmer_key      (req_kmer_key),
      .req_letter        (req_letter),
      .req_side          (req_side),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bin_index     (rsp_bin_index),
      .rsp_bin_value     (rsp_bin_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic kovh_pkg::count_type bump(input kovh_pkg::count_type acc,
                                                input int unsigned inc);
      logic [kovh_pkg::COUNT_BITS:0] s;
      s = {1'b0, acc} + inc;
      return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[kovh_pkg::COUNT_BITS-1:0];
   endfunction

   task automatic clear_histogram();
      grp_key = '0;
      grp_open = 1'b0;
      grp_side0 = '0;
      grp_side1 = '0;
      for (int i = 0; i < kovh_pkg::NUM_BINS; i++) begin
         hist_bins[i] = '0;
      end
      hist_total = '0;
   endtask

   task automatic close_group();
      int unsigned c0;
      int unsigned c1;
      c0 = $countones(grp_side0);
      c1 = $countones(grp_side1);
      if (c0 < kovh_pkg::NUM_BINS && c1 < kovh_pkg::NUM_BINS) begin
         hist_bins[c1] = bump(hist_bins[c1], c0);
         hist_bins[c0] = bump(hist_bins[c0], c1);
      end
      hist_total = bump(hist_total, c0 * c1);
      grp_side0 = '0;
      grp_side1 = '0;
      grp_open = 1'b0;
   endtask

   // one accepted record: update groups, queue the drain on end of stream
   task automatic predict_record(input kovh_pkg::key_type key,
                                 input kovh_pkg::letter_type letter,
                                 input logic side, input logic eos);
      bin_word_type w;
      if (grp_open && key != grp_key) begin
         close_group();
      end
      if (!grp_open) begin
         grp_open = 1'b1;
         grp_key = key;
         grp_side0 = '0;
         grp_side1 = '0;
      end
      if (letter < kovh_pkg::ALPHABET) begin
         if (side) begin
            grp_side1[letter] = 1'b1;
         end else begin
            grp_side0[letter] = 1'b1;
         end
      end
      if (eos) begin
         close_group();
         for (int i = 0; i < kovh_pkg::NUM_BINS; i++) begin
            w.idx = kovh_pkg::bin_index_type'(i);
            w.value = kovh_pkg::value_type'(hist_bins[i]);
            w.last = 1'b0;
            pending_bins.push_back(w);
         end
         w.idx = kovh_pkg::bin_index_type'(kovh_pkg::LAST_IDX);
         w.value = kovh_pkg::value_type'(hist_total);
         w.last = 1'b1;
         pending_bins.push_back(w);
         clear_histogram();
      end
   endtask

   initial begin
      clear_histogram();
   end

   // random stalls on the result side
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      bin_word_type w;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_record(req_kmer_key, req_letter, req_side, req_end_of_stream);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_bins.size() == 0) begin
               $display("%0t: unexpected word idx=%0d value=%0h last=%0b", $time,
                        rsp_bin_index, rsp_bin_value, rsp_last_of_run);
               error_count++;
            end else begin
               w = pending_bins.pop_front();
               words_checked++;
               if (rsp_bin_index !== w.idx) begin
                  $display("%0t: bin_index expected %0d actual %0d", $time,
                           w.idx, rsp_bin_index);
                  error_count++;
               end
               if (rsp_bin_value !== w.value) begin
                  $display("%0t: bin_value (bin %0d) expected %0h actual %0h", $time,
                           w.idx, w.value, rsp_bin_value);
                  error_count++;
               end
               if (rsp_last_of_run !== w.last) begin
                  $display("%0t: last_of_run (bin %0d) expected %0b actual %0b", $time,
                           w.idx, w.last, rsp_last_of_run);
                  error_count++;
               end
               if (w.last) begin
                  drains_seen++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words still pending", $time,
                     pending_bins.size());
            $display("** kmer_overlap_histogram_top: FAILED **");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // drive one record word and hold it until accepted
   task automatic send_record(input kovh_pkg::key_type key,
                              input kovh_pkg::letter_type letter,
                              input logic side, input logic eos);
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_kmer_key <= key;
      req_letter <= letter;
      req_side <= side;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      records_sent++;
   endtask

   // lower valid and wait for every queued bin word to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      // let the monitor book the last accepted record first
      @(posedge clock);
      while (pending_bins.size() != 0) @(posedge clock);
   endtask

   function automatic kovh_pkg::key_type random_key();
      return kovh_pkg::key_type'({$urandom(), $urandom()});
   endfunction

   function automatic kovh_pkg::letter_type random_letter();
      // mostly letters inside the alphabet, some that must be ignored
      if ($urandom_range(3) == 0) begin
         return kovh_pkg::letter_type'($urandom_range(15));
      end
      return kovh_pkg::letter_type'($urandom_range(kovh_pkg::ALPHABET - 1));
   endfunction

   // sorted stream with random group sizes, some unsorted keys and extremes
   task automatic send_random_stream(input int n_items);
      kovh_pkg::key_type key;
      int r;
      key = random_key();
      if ($urandom_range(1) == 0) begin
         key = kovh_pkg::key_type'($urandom_range(1000));
      end
      for (int j = 0; j < n_items; j++) begin
         if (j > 0) begin
            r = $urandom_range(99);
            if (r < 45) begin
               key = key;
            end else if (r < 85) begin
               key = key + kovh_pkg::key_type'($urandom_range(1, 3));
            end else if (r < 95) begin
               key = random_key();
            end else begin
               key = ($urandom_range(1) == 0) ? '0 : '1;
            end
         end
         send_record(key, random_letter(), 1'($urandom_range(1)), j == n_items - 1);
      end
   endtask

   task automatic test_directed();
      kovh_pkg::key_type kmax;
      kmax = '1;
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      // single record stream right after reset
      send_record('0, 4'd0, 1'b0, 1'b1);
      // every letter on side 0 under the largest key
      for (int i = 0; i < kovh_pkg::ALPHABET; i++) begin
         send_record(kmax, kovh_pkg::letter_type'(i), 1'b0, 1'b0);
      end
      send_record(kmax, 4'd7, 1'b1, 1'b0);
      send_record(kmax, 4'd15, 1'b1, 1'b0);
      send_record(kmax, 4'd8, 1'b0, 1'b0);
      send_record(kovh_pkg::key_type'(64'h5555_5555_5555_5555), 4'd3, 1'b1, 1'b0);
      send_record(kovh_pkg::key_type'(64'h2aaa_aaaa_aaaa_aaaa), 4'd5, 1'b0, 1'b0);
      // key seen before comes back and opens a fresh group
      send_record(kmax, 4'd9, 1'b0, 1'b0);
      send_record(kmax, 4'd0, 1'b1, 1'b1);
      // end of stream on a new key closes the old group first
      send_record(kovh_pkg::key_type'(123), 4'd2, 1'b0, 1'b0);
      send_record(kovh_pkg::key_type'(123), 4'd6, 1'b1, 1'b0);
      send_record('0, 4'd4, 1'b1, 1'b1);
   endtask

   task automatic test_pause_after_drain();
      sender_idle_pct = 0;
      recv_stall_pct = 50;
      send_random_stream(6);
      wait_drained();
      send_random_stream(4);
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                    input int n_items);
      int target;
      int len;
      sender_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      target = records_sent + n_items;
      while (records_sent < target) begin
         len = $urandom_range(2, 14);
         if (records_sent + len > target) begin
            len = (target - records_sent < 1) ? 1 : target - records_sent;
         end
         send_random_stream(len);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pause_after_drain();
      test_random_phase(0, 0, 40);
      test_random_phase(50, 0, 40);
      test_random_phase(0, 50, 40);
      test_random_phase(13, 13, 40);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d records and %0d drains, %0d bin words checked",
               records_sent, drains_seen, words_checked);
      $display("streams ran with no idling, sender gaps, receiver stalls and both");
      if (error_count == 0 && pending_bins.size() == 0) begin
         $display("** kmer_overlap_histogram_top: PASSED **");
      end else begin
         $display("** kmer_overlap_histogram_top: FAILED **");
      end
      $finish;
   end

endmodule
